FILE: src/sao_pkg.sv
package sao_pkg;

    localparam int CH_W         = 8;
    localparam int PIX_W        = 32;
    localparam int NUM_W        = 16;
    localparam int N_CH         = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int FRONT_STAGES = 6;

    // x / 255 == (x * RECIP_255) >> RECIP_SHIFT for every x below 2^16
    localparam logic [16:0] RECIP_255   = 17'd32897;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [CH_W-1:0] FULL = 8'hff;
    localparam logic [CH_W-1:0] HALF = 8'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED    = 2'd0,
        CFG_GREEN  = 2'd1,
        CFG_BLUE   = 2'd2,
        CFG_TRANSP = 2'd3
    } cfg_idx_t;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [NUM_W-1:0] num_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t transp;
    } cfg_t;

    // One word moving through the divider row; channel 0 blue, 1 green, 2 red.
    typedef struct packed {
        logic                 bypass;
        logic [PIX_W-1:0]     px;
        chan_t                oa;
        chan_t [N_CH-1:0]     q;
        num_t  [N_CH-1:0]     rem;
    } lane_t;

endpackage

FILE: src/sao_if.sv
interface sao_in_if;
    import sao_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] dest_pixel;
    logic [CH_W-1:0]  coverage;

    modport source (output valid, output dest_pixel, output coverage, input ready);
    modport sink   (input valid, input dest_pixel, input coverage, output ready);
endinterface

interface sao_out_if;
    import sao_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

FILE: src/sao_front.sv
module sao_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sao_pkg::cfg_t         cfg,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [31:0]           up_pixel,
    input  logic [7:0]            up_coverage,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output sao_pkg::lane_t        dn_lane
);
    import sao_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        num_t             prod;
        chan_t            sa;
        num_t             dwn;
        chan_t            dw;
        chan_t            oa;
        num_t [N_CH-1:0]  fs;
        num_t [N_CH-1:0]  bd;
        num_t [N_CH-1:0]  num;
    } front_t;

    function automatic chan_t div255(input num_t x);
        logic [32:0] p;
        p = {17'b0, x} * {16'b0, RECIP_255};
        return p[RECIP_SHIFT +: CH_W];
    endfunction

    front_t                  stg_reg  [FRONT_STAGES];
    front_t                  stg_next [FRONT_STAGES];
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_shift;
    logic [FRONT_STAGES:0]   en;
    chan_t [N_CH-1:0]        fg;

    assign fg[0] = cfg.blue;
    assign fg[1] = cfg.green;
    assign fg[2] = cfg.red;

    // valid flag each stage takes when it advances
    assign vld_shift = {vld_reg[FRONT_STAGES-2:0], up_valid};

    always_comb
    begin
        en[FRONT_STAGES] = dn_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign up_ready = en[0];

    always_comb
    begin
        // source alpha numerator
        stg_next[0]      = '0;
        stg_next[0].px   = up_pixel;
        stg_next[0].prod = num_t'(FULL - cfg.transp) * num_t'(up_coverage) + num_t'(HALF);

        stg_next[1]    = stg_reg[0];
        stg_next[1].sa = div255(stg_reg[0].prod);

        // destination weight numerator
        stg_next[2]     = stg_reg[1];
        stg_next[2].dwn = num_t'(stg_reg[1].px[31:24]) * num_t'(FULL - stg_reg[1].sa)
                          + num_t'(HALF);

        stg_next[3]    = stg_reg[2];
        stg_next[3].dw = div255(stg_reg[2].dwn);

        stg_next[4]    = stg_reg[3];
        stg_next[4].oa = stg_reg[3].sa + stg_reg[3].dw;
        for (int c = 0; c < N_CH; c++)
        begin
            stg_next[4].fs[c] = num_t'(fg[c]) * num_t'(stg_reg[3].sa);
            stg_next[4].bd[c] = num_t'(stg_reg[3].px[c*CH_W +: CH_W]) * num_t'(stg_reg[3].dw);
        end

        // rounded mix numerator, fits 16 bits since it is at most 255 * oa + 127
        stg_next[5] = stg_reg[4];
        for (int c = 0; c < N_CH; c++)
        begin
            stg_next[5].num[c] = stg_reg[4].fs[c] + stg_reg[4].bd[c]
                                 + num_t'(stg_reg[4].oa >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < FRONT_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_shift[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FRONT_STAGES; k++)
        begin
            if (en[k])
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    assign dn_valid = vld_reg[FRONT_STAGES-1];

    always_comb
    begin
        dn_lane        = '0;
        dn_lane.bypass = (stg_reg[FRONT_STAGES-1].sa == '0);
        dn_lane.px     = stg_reg[FRONT_STAGES-1].px;
        dn_lane.oa     = stg_reg[FRONT_STAGES-1].oa;
        dn_lane.rem    = stg_reg[FRONT_STAGES-1].num;
    end

endmodule

FILE: src/sao_div_cell.sv
module sao_div_cell #(
    parameter int BIT = 7
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  sao_pkg::lane_t  up_lane,
    output logic            dn_valid,
    input  logic            dn_ready,
    output sao_pkg::lane_t  dn_lane
);
    import sao_pkg::*;

    logic  vld_reg;
    lane_t lane_reg;
    lane_t lane_next;
    num_t  dsr;

    assign up_ready = !vld_reg || dn_ready;
    assign dsr      = num_t'(up_lane.oa) << BIT;

    // one restoring step per channel: subtract the shifted divisor if it fits
    always_comb
    begin
        lane_next = up_lane;
        for (int c = 0; c < N_CH; c++)
        begin
            if (up_lane.rem[c] >= dsr)
            begin
                lane_next.rem[c]    = up_lane.rem[c] - dsr;
                lane_next.q[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            lane_reg <= lane_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_lane  = lane_reg;

endmodule

FILE: src/straight_alpha_over_blend.sv
// Channel   Dir  Handshake       Word
// px_in     in   valid / ready   dest_pixel[31:0] (B,G,R,A bytes), coverage[7:0]
// px_out    out  valid / ready   out_pixel[31:0] (B,G,R,A bytes)
// cfg       in   cfg_we          cfg_index[1:0], cfg_wdata[7:0]
//
// One word per clock sustained while px_out is not stalled; the pipe is six front
// stages for the alpha terms and eight divider cells, one quotient bit per cell.
// rst_n clears every valid flag and loads the color registers (white, opaque).
// Each stage holds its word only while the stage after it is full and stalled,
// so bubbles collapse; px_in drops ready only when all fourteen stages hold a
// word and px_out is stalled.
module straight_alpha_over_blend (
    input  logic                                clk,
    input  logic                                rst_n,
    sao_in_if.sink                              px_in,
    sao_out_if.source                           px_out,
    input  logic                                cfg_we,
    input  logic [sao_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sao_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import sao_pkg::*;

    cfg_t  cfg_reg;

    // divider row links: link 0 is the front output, link CH_W the last cell
    lane_t           lane  [CH_W+1];
    logic [CH_W:0]   vld;
    logic [CH_W:0]   rdy;

    // color registers; the user must write them only while the pipe is empty, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red    <= FULL;
            cfg_reg.green  <= FULL;
            cfg_reg.blue   <= FULL;
            cfg_reg.transp <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RED:    cfg_reg.red    <= cfg_wdata;
                CFG_GREEN:  cfg_reg.green  <= cfg_wdata;
                CFG_BLUE:   cfg_reg.blue   <= cfg_wdata;
                CFG_TRANSP: cfg_reg.transp <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // source alpha, destination weight, out alpha and the three mix numerators
    sao_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .up_valid    (px_in.valid),
        .up_ready    (px_in.ready),
        .up_pixel    (px_in.dest_pixel),
        .up_coverage (px_in.coverage),
        .dn_valid    (vld[0]),
        .dn_ready    (rdy[0]),
        .dn_lane     (lane[0])
    );

    // row of divider cells, most significant quotient bit first
    for (genvar i = 0; i < CH_W; i++)
    begin : g_cell
        sao_div_cell #(
            .BIT (CH_W - 1 - i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (vld[i]),
            .up_ready (rdy[i]),
            .up_lane  (lane[i]),
            .dn_valid (vld[i+1]),
            .dn_ready (rdy[i+1]),
            .dn_lane  (lane[i+1])
        );
    end

    // last cell register is the output register
    assign rdy[CH_W]    = px_out.ready;
    assign px_out.valid = vld[CH_W];

    // zero source alpha passes the destination pixel untouched
    assign px_out.out_pixel = lane[CH_W].bypass
                              ? lane[CH_W].px
                              : {lane[CH_W].oa, lane[CH_W].q[2], lane[CH_W].q[1],
                                 lane[CH_W].q[0]};

endmodule

FILE: src/sao_checker.sv
module sao_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_pixel
);
    localparam int DEPTH = 14;

    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_take && !out_take)
        begin
            cnt_next = cnt_reg + 5'd1;
        end
        else if (!in_take && out_take)
        begin
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // never more words in flight than pipeline stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 5'(DEPTH))
        else $error("more words in flight than stages");

    // no result without a word inside
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !out_valid)
        else $error("result with nothing in flight");

    // empty pipe always takes a word
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> in_ready)
        else $error("input stalled with empty pipe");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_pixel)))
        else $error("stalled result dropped or changed");

endmodule

bind straight_alpha_over_blend sao_checker u_sao_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (px_in.valid),
    .in_ready  (px_in.ready),
    .out_valid (px_out.valid),
    .out_ready (px_out.ready),
    .out_pixel (px_out.out_pixel)
);

FILE: test/straight_alpha_over_blend_tb.sv
module straight_alpha_over_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sao_pkg::*;

    // 6 front stages plus 8 divider cells, with a little margin on top
    localparam int PIPE_LAT   = FRONT_STAGES + CH_W + 4;
    // cycles with no word moving on either channel before the run is abandoned
    localparam int STUCK_LIMIT = 1000;
    localparam int RAND_ITEMS  = 2000;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sao_in_if  pix_in_bus ();
    sao_out_if pix_out_bus ();

    // shadow copy of the color registers, updated on every write we issue
    cfg_t ink;

    // blended pixels still owed by the block, oldest first
    logic [PIX_W-1:0] pending_pixels[$];

    int mismatches = 0;
    int stuck_cycles = 0;

    // idle odds in percent, changed from phase to phase
    int in_gap_pct = 0;
    int out_stall_pct = 0;

    straight_alpha_over_blend DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .px_in     (pix_in_bus),
        .px_out    (pix_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Composite the overlay color over one straight-alpha pixel, as the block should.
    function automatic logic [PIX_W-1:0] predict_over(input logic [PIX_W-1:0] px,
                                                      input chan_t cov);
        int unsigned opacity;
        int unsigned src_a;
        int unsigned dst_a;
        int unsigned dst_w;
        int unsigned out_a;
        int unsigned fg[N_CH];
        int unsigned bg;
        logic [PIX_W-1:0] res;
        opacity = 255 - int'(ink.transp);
        src_a   = (opacity * int'(cov) + 127) / 255;
        // nothing to paint: the pixel goes through untouched
        if (src_a == 0)
            return px;
        dst_a = px[31:24];
        dst_w = (dst_a * (255 - src_a) + 127) / 255;
        out_a = src_a + dst_w;
        fg[0] = ink.blue;
        fg[1] = ink.green;
        fg[2] = ink.red;
        for (int i = 0; i < N_CH; i++)
        begin
            bg = px[8*i +: 8];
            res[8*i +: 8] = 8'((fg[i] * src_a + bg * dst_w + (out_a >> 1)) / out_a);
        end
        res[31:24] = out_a[7:0];
        return res;
    endfunction

    // Drive the output ready at random against the current stall odds.
    always @(negedge clk)
    begin
        pix_out_bus.ready = ($urandom_range(99) >= out_stall_pct);
    end

    // Compare every word that leaves the block with the oldest pixel owed.
    always @(posedge clk)
    begin : check_word
        logic [PIX_W-1:0] want;
        if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %08h",
                         $time, pix_out_bus.out_pixel);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pix_out_bus.out_pixel !== want)
                begin
                    $display("%0t: out_pixel mismatch, expected %08h, actual %08h",
                             $time, want, pix_out_bus.out_pixel);
                    mismatches++;
                end
            end
        end
    end

    // Abandon the run when no word has moved on either side for too long.
    always @(posedge clk)
    begin
        if ((pix_in_bus.valid && pix_in_bus.ready) ||
            (pix_out_bus.valid && pix_out_bus.ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one pixel, hold it until taken, and log what it should turn into.
    // Enter and leave at a falling edge; valid is left high for the next word.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input chan_t cov);
        while ($urandom_range(99) < in_gap_pct)
        begin
            pix_in_bus.valid = 1'b0;
            @(negedge clk);
        end
        pix_in_bus.valid      = 1'b1;
        pix_in_bus.dest_pixel = px;
        pix_in_bus.coverage   = cov;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        pending_pixels.push_back(predict_over(px, cov));
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed pixel has come back, then
    // let the pipe run empty.
    task automatic wait_drained();
        pix_in_bus.valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LAT) @(negedge clk);
    endtask

    // Write one color register; only call with the block idle.
    task automatic write_reg(input cfg_idx_t idx, input chan_t val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_RED:    ink.red    = val;
            CFG_GREEN:  ink.green  = val;
            CFG_BLUE:   ink.blue   = val;
            CFG_TRANSP: ink.transp = val;
            default: ;
        endcase
    endtask

    task automatic set_ink(input chan_t r, input chan_t g, input chan_t b, input chan_t t);
        wait_drained();
        write_reg(CFG_RED, r);
        write_reg(CFG_GREEN, g);
        write_reg(CFG_BLUE, b);
        write_reg(CFG_TRANSP, t);
    endtask

    // Favor the ends of the byte range, where rounding and bypass live.
    function automatic chan_t pick_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h01;
            3: return 8'hfe;
            default: return 8'($urandom);
        endcase
    endfunction

    // Directed pixels: bypass, full cover, rounding down to no paint, empty
    // destination, color register extremes.
    task automatic test_directed_cases();
        // reset color: opaque white
        send_pixel(32'h0000_0000, 8'h00);
        send_pixel(32'hffff_ffff, 8'h00);
        send_pixel(32'h0000_0000, 8'hff);
        send_pixel(32'hffff_ffff, 8'hff);
        send_pixel(32'h8012_3456, 8'h80);
        send_pixel(32'h00ab_cdef, 8'h01);
        send_pixel(32'hff00_0000, 8'h01);
        // nearly transparent ink: coverage 1 rounds to no paint, 128 to one step
        set_ink(8'h00, 8'h80, 8'hff, 8'hfe);
        send_pixel(32'hff10_2030, 8'h01);
        send_pixel(32'hff10_2030, 8'h80);
        send_pixel(32'h7f55_aa33, 8'hff);
        send_pixel(32'h0000_0000, 8'hff);
        // fully transparent ink never paints
        set_ink(8'h00, 8'h80, 8'hff, 8'hff);
        send_pixel(32'h1234_5678, 8'hff);
        send_pixel(32'hffff_ffff, 8'hff);
        // opaque black
        set_ink(8'h00, 8'h00, 8'h00, 8'h00);
        send_pixel(32'hffff_ffff, 8'hff);
        send_pixel(32'hffff_ffff, 8'h7f);
        send_pixel(32'h01ff_ffff, 8'h80);
        // half transparent mixed color
        set_ink(8'h01, 8'hfe, 8'h7f, 8'h80);
        send_pixel(32'h8080_8080, 8'hc0);
        send_pixel(32'hff00_ff00, 8'h40);
        send_pixel(32'h00ff_00ff, 8'hff);
        wait_drained();
    endtask

    // Random pixels under one pair of idle odds, over two color settings,
    // with a full stop halfway through each.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int count);
        logic [PIX_W-1:0] px;
        chan_t cov;
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        for (int s = 0; s < 2; s++)
        begin
            set_ink(pick_level(), pick_level(), pick_level(), pick_level());
            for (int n = 0; n < count / 2; n++)
            begin
                px = $urandom;
                // push the destination alpha to its ends now and then
                case ($urandom_range(5))
                    0: px[31:24] = 8'h00;
                    1: px[31:24] = 8'hff;
                    default: ;
                endcase
                cov = pick_level();
                send_pixel(px, cov);
                if (n == count / 4)
                    wait_drained();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        pix_in_bus.valid      = 1'b0;
        pix_in_bus.dest_pixel = '0;
        pix_in_bus.coverage   = '0;
        ink.red    = 8'hff;
        ink.green  = 8'hff;
        ink.blue   = 8'hff;
        ink.transp = 8'h00;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_random_traffic(0, 0, RAND_ITEMS / 4);
        test_random_traffic(73, 0, RAND_ITEMS / 4);
        test_random_traffic(0, 73, RAND_ITEMS / 4);
        test_random_traffic(23, 23, RAND_ITEMS / 4);

        wait_drained();
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
